### hw/rtl/qtws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtws_pkg
// shared types and codes of the two-stack queue
// ----------------------------------------------------------------------------
package qtws_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned StatusW = 2;

  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  localparam logic [StatusW-1:0] STATUS_OK    = 2'd0;
  localparam logic [StatusW-1:0] STATUS_FULL  = 2'd1;
  localparam logic [StatusW-1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic                    kind;
    logic signed [WordW-1:0] value;
  } req_t;

  typedef struct packed {
    logic signed [WordW-1:0] data;
    logic [StatusW-1:0]      status;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MV_RD,
    S_MV_WR,
    S_POP,
    S_RESP
  } state_e;

  typedef struct packed {
    logic               req_load;
    logic               push;
    logic               mv_rd;
    logic               mv_wr;
    logic               pop;
    logic               rsp_load;
    logic               rsp_pop;
    logic [StatusW-1:0] rsp_status;
  } cmd_t;

  typedef struct packed {
    logic kind;
    logic in_empty;
    logic in_full;
    logic out_empty;
    logic out_free;
  } stat_t;

endpackage

### hw/rtl/qtws_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtws_ctrl
// sequencer for enqueue, dequeue and the stack-to-stack transfer
// ----------------------------------------------------------------------------
module qtws_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  qtws_pkg::stat_t stat_i,
  output qtws_pkg::cmd_t  cmd_o
);
  import qtws_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.kind == KIND_ENQ) begin
          if (stat_i.out_free) state_d = S_IDLE;
        end else if (!stat_i.out_empty) begin
          state_d = S_POP;
        end else if (stat_i.in_empty) begin
          if (stat_i.out_free) state_d = S_IDLE;
        end else begin
          state_d = S_MV_RD;
        end
      end
      S_MV_RD: state_d = S_MV_WR;
      S_MV_WR: state_d = stat_i.in_empty ? S_POP : S_MV_RD;
      S_POP:   state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.rsp_status = STATUS_OK;
    unique case (state_q)
      S_IDLE: cmd_o.req_load = in_valid_i;
      S_EXEC: begin
        if (stat_i.kind == KIND_ENQ) begin
          cmd_o.push       = stat_i.out_free && !stat_i.in_full;
          cmd_o.rsp_load   = stat_i.out_free;
          cmd_o.rsp_status = stat_i.in_full ? STATUS_FULL : STATUS_OK;
        end else if (stat_i.out_empty && stat_i.in_empty) begin
          cmd_o.rsp_load   = stat_i.out_free;
          cmd_o.rsp_status = STATUS_EMPTY;
        end
      end
      S_MV_RD: cmd_o.mv_rd = 1'b1;
      S_MV_WR: cmd_o.mv_wr = 1'b1;
      S_POP:   cmd_o.pop   = 1'b1;
      S_RESP: begin
        cmd_o.rsp_load = stat_i.out_free;
        cmd_o.rsp_pop  = 1'b1;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

### hw/rtl/qtws_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qtws_dp
// two stack memories, their counts, request and response registers
// ----------------------------------------------------------------------------
module qtws_dp #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qtws_pkg::req_t  in_req_i,
  output qtws_pkg::rsp_t  out_rsp_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  qtws_pkg::cmd_t  cmd_i,
  output qtws_pkg::stat_t stat_o
);
  import qtws_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  logic [WordW-1:0] in_mem  [STACK_DEPTH];
  logic [WordW-1:0] out_mem [STACK_DEPTH];

  req_t             req_q;
  logic [CntW-1:0]  in_cnt_q, in_cnt_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic [CntW-1:0]  in_top, out_top;
  logic [WordW-1:0] in_rd_q, out_rd_q;
  rsp_t             rsp_q;
  logic             out_valid_q;
  logic             out_free;

  assign in_top   = in_cnt_q - 1'b1;
  assign out_top  = out_cnt_q - 1'b1;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    if (cmd_i.push)  in_cnt_d  = in_cnt_q + 1'b1;
    if (cmd_i.mv_rd) in_cnt_d  = in_top;
    if (cmd_i.mv_wr) out_cnt_d = out_cnt_q + 1'b1;
    if (cmd_i.pop)   out_cnt_d = out_top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      if (cmd_i.rsp_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      in_mem[in_cnt_q[IdxW-1:0]] <= req_q.value;
    end
    if (cmd_i.mv_rd) begin
      in_rd_q <= in_mem[in_top[IdxW-1:0]];
    end
  end

  // output stack
  always_ff @(posedge clk_i) begin
    if (cmd_i.mv_wr) begin
      out_mem[out_cnt_q[IdxW-1:0]] <= in_rd_q;
    end
    if (cmd_i.pop) begin
      out_rd_q <= out_mem[out_top[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      req_q <= in_req_i;
    end
    if (cmd_i.rsp_load) begin
      rsp_q.data   <= cmd_i.rsp_pop ? out_rd_q : '0;
      rsp_q.status <= cmd_i.rsp_status;
    end
  end

  assign out_rsp_o   = rsp_q;
  assign out_valid_o = out_valid_q;

  assign stat_o.kind      = req_q.kind;
  assign stat_o.in_empty  = (in_cnt_q == '0);
  assign stat_o.in_full   = (in_cnt_q == CntW'(STACK_DEPTH));
  assign stat_o.out_empty = (out_cnt_q == '0);
  assign stat_o.out_free  = out_free;

endmodule

### hw/rtl/queue_from_two_stacks.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// queue_from_two_stacks
// fifo built from an input stack and an output stack in two memories
// the response is registered: enqueue and empty dequeue load it in the exec state,
// a dequeue with data ready in the resp state after the pop state
// a dequeue that finds the output stack empty first moves all input words,
// each by a read then a write state; a new request is taken only in idle
// reset clears both stack counts at once; memory contents are left as they are
// ----------------------------------------------------------------------------
module queue_from_two_stacks #(
  parameter int unsigned STACK_DEPTH = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  qtws_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output qtws_pkg::rsp_t out_rsp_o
);
  import qtws_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  qtws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  qtws_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_rsp_o   (out_rsp_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule
